@@ src/dkp_pkg.sv @@
// Shared types, field widths and operation codes of the dual-key node pool.
package dkp_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [FREQ_W-1:0]   freq_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_INSERT  = 2'd0;
  localparam mode_t MODE_EXTRACT = 2'd1;
  localparam mode_t MODE_PRUNE   = 2'd2;
  localparam mode_t MODE_NOP     = 2'd3;

  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  localparam freq_t FREQ_RESET = 16'd1;

  typedef struct packed {
    data_t   lower;
    data_t   upper;
    handle_t handle;
    data_t   seq;
  } entry_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic older;
  } cmp_res_t;

endpackage

@@ src/dkp_if.sv @@
// Request, result and configuration channel interfaces of the node pool.
interface dkp_req_if;
  logic              valid;
  logic              ready;
  dkp_pkg::mode_t    mode;
  dkp_pkg::data_t    lower_bound;
  dkp_pkg::data_t    upper_bound;
  dkp_pkg::handle_t  node_handle;
  dkp_pkg::data_t    threshold;

  modport source (output valid, mode, lower_bound, upper_bound, node_handle, threshold,
                  input ready);
  modport sink (input valid, mode, lower_bound, upper_bound, node_handle, threshold,
                output ready);
endinterface

interface dkp_rsp_if;
  logic              valid;
  logic              ready;
  dkp_pkg::status_t  status;
  dkp_pkg::handle_t  out_handle;
  dkp_pkg::data_t    out_lower;
  dkp_pkg::data_t    out_upper;
  dkp_pkg::count_t   removed_count;
  dkp_pkg::data_t    inserted_total;

  modport source (output valid, status, out_handle, out_lower, out_upper, removed_count,
                  inserted_total, input ready);
  modport sink (input valid, status, out_handle, out_lower, out_upper, removed_count,
                inserted_total, output ready);
endinterface

interface dkp_cfg_if;
  logic           valid;
  logic           ready;
  dkp_pkg::freq_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ src/dkp_store.sv @@
// Node storage memory with one write port and one registered read port.
module dkp_store #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned HANDLE_BITS = 16,
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk_i,
  input  logic [IW-1:0]     rd_addr_i,
  output dkp_pkg::entry_t   rd_entry_o,
  output logic              rd_valid_o,
  input  logic [IW-1:0]     wr_addr_i,
  input  logic              data_we_i,
  input  dkp_pkg::entry_t   wr_entry_i,
  input  logic              valid_we_i,
  input  logic              valid_wd_i
);

  localparam int unsigned HW = (HANDLE_BITS < dkp_pkg::HANDLE_W) ? HANDLE_BITS
                                                                 : dkp_pkg::HANDLE_W;

  dkp_pkg::data_t lower_mem  [CAPACITY];
  dkp_pkg::data_t upper_mem  [CAPACITY];
  dkp_pkg::data_t seq_mem    [CAPACITY];
  logic [HW-1:0]  handle_mem [CAPACITY];
  logic           valid_mem  [CAPACITY];

  dkp_pkg::data_t rd_lower_q;
  dkp_pkg::data_t rd_upper_q;
  dkp_pkg::data_t rd_seq_q;
  logic [HW-1:0]  rd_handle_q;
  logic           rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (data_we_i) begin
      lower_mem[wr_addr_i]  <= wr_entry_i.lower;
      upper_mem[wr_addr_i]  <= wr_entry_i.upper;
      seq_mem[wr_addr_i]    <= wr_entry_i.seq;
      handle_mem[wr_addr_i] <= wr_entry_i.handle[HW-1:0];
    end
    if (valid_we_i) begin
      valid_mem[wr_addr_i] <= valid_wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_lower_q  <= lower_mem[rd_addr_i];
    rd_upper_q  <= upper_mem[rd_addr_i];
    rd_seq_q    <= seq_mem[rd_addr_i];
    rd_handle_q <= handle_mem[rd_addr_i];
    rd_valid_q  <= valid_mem[rd_addr_i];
  end

  assign rd_entry_o.lower  = rd_lower_q;
  assign rd_entry_o.upper  = rd_upper_q;
  assign rd_entry_o.seq    = rd_seq_q;
  assign rd_entry_o.handle = dkp_pkg::handle_t'(rd_handle_q);
  assign rd_valid_o        = rd_valid_q;

endmodule

@@ src/dkp_cmp.sv @@
// Shared compare unit: signed key order, key equality and node age order.
module dkp_cmp (
  input  dkp_pkg::data_t    a_key_i,
  input  dkp_pkg::data_t    b_key_i,
  input  dkp_pkg::data_t    ref_seq_i,
  input  dkp_pkg::data_t    a_seq_i,
  input  dkp_pkg::data_t    b_age_i,
  output dkp_pkg::data_t    a_age_o,
  output dkp_pkg::cmp_res_t res_o
);

  assign a_age_o     = ref_seq_i - a_seq_i;
  assign res_o.lt    = $signed(a_key_i) < $signed(b_key_i);
  assign res_o.eq    = a_key_i == b_key_i;
  assign res_o.older = a_age_o > b_age_i;

endmodule

@@ src/dual_key_node_pool.sv @@
// Top level of the dual-key branch-and-bound node pool.
// A request word on in_i carries a mode: insert a node, extract a node or
// prune by threshold; a fourth code does nothing. Each request gives exactly
// one result word on out_o. The single register, the extraction frequency,
// is to be written through cfg_i only while the pool is idle; the block
// itself does not enforce this. Insert, extract and prune each sweep all
// CAPACITY entries through the one read port of the node memory, feeding
// one shared compare unit; a new word is taken only once the previous one
// has finished. A no-op word skips the sweep and goes straight to the
// finish state. After reset a clearing pass over all CAPACITY entries
// marks every entry free; in_i stays not ready during it, while cfg_i is
// always ready. The result sits in an output register until taken. A new
// request is accepted while it waits, but that request holds its own
// result, and the node write or removal of an insert or extract, until the
// output register is free again; a prune removes its nodes during the
// sweep.
module dual_key_node_pool #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dkp_req_if.sink      in_i,
  dkp_rsp_if.source    out_o,
  dkp_cfg_if.sink      cfg_i
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]        state_q;
  logic [CW-1:0]     cnt_q;
  logic              rv_q;
  logic [IW-1:0]     ridx_q;
  dkp_pkg::mode_t    op_q;
  logic              by_upper_q;
  logic              found_q;
  logic [CW-1:0]     rm_cnt_q;
  dkp_pkg::data_t    next_seq_q;
  dkp_pkg::data_t    total_q;
  dkp_pkg::freq_t    phase_q;
  dkp_pkg::freq_t    freq_q;
  logic              out_valid_q;

  dkp_pkg::data_t    lower_q;
  dkp_pkg::data_t    upper_q;
  dkp_pkg::handle_t  handle_q;
  dkp_pkg::data_t    thr_q;
  logic [IW-1:0]     best_idx_q;
  dkp_pkg::data_t    best_key_q;
  dkp_pkg::data_t    best_age_q;
  dkp_pkg::data_t    best_lower_q;
  dkp_pkg::data_t    best_upper_q;
  dkp_pkg::handle_t  best_handle_q;

  dkp_pkg::status_t  out_status_q;
  dkp_pkg::handle_t  out_handle_q;
  dkp_pkg::data_t    out_lower_q;
  dkp_pkg::data_t    out_upper_q;
  dkp_pkg::count_t   out_removed_q;
  dkp_pkg::data_t    out_total_q;

  dkp_pkg::entry_t   rd_entry;
  logic              rd_valid;
  logic [IW-1:0]     wr_addr;
  logic              data_we;
  dkp_pkg::entry_t   wr_entry;
  logic              valid_we;
  logic              valid_wd;

  dkp_pkg::data_t    key;
  dkp_pkg::data_t    a_key;
  dkp_pkg::data_t    b_key;
  dkp_pkg::data_t    a_age;
  dkp_pkg::cmp_res_t cmp_res;

  logic              accept;
  logic              take;
  logic              free_hit;
  logic              prune_hit;
  logic              fin_go;
  logic [dkp_pkg::FREQ_W:0] phase_inc;
  logic              freq_multi;
  logic              upper_turn;

  dkp_store #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rd_addr_i  (cnt_q[IW-1:0]),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid),
    .wr_addr_i  (wr_addr),
    .data_we_i  (data_we),
    .wr_entry_i (wr_entry),
    .valid_we_i (valid_we),
    .valid_wd_i (valid_wd)
  );

  dkp_cmp u_cmp (
    .a_key_i   (a_key),
    .b_key_i   (b_key),
    .ref_seq_i (next_seq_q),
    .a_seq_i   (rd_entry.seq),
    .b_age_i   (best_age_q),
    .a_age_o   (a_age),
    .res_o     (cmp_res)
  );

  assign key   = by_upper_q ? rd_entry.upper : rd_entry.lower;
  assign a_key = (op_q == dkp_pkg::MODE_PRUNE) ? thr_q : key;
  assign b_key = (op_q == dkp_pkg::MODE_PRUNE) ? rd_entry.lower : best_key_q;

  assign take      = rv_q && rd_valid && (!found_q || cmp_res.lt || (cmp_res.eq && cmp_res.older));
  assign free_hit  = rv_q && !rd_valid && !found_q;
  assign prune_hit = rv_q && rd_valid && cmp_res.lt;

  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign fin_go      = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  assign phase_inc  = {1'b0, phase_q} + {{dkp_pkg::FREQ_W{1'b0}}, 1'b1};
  assign freq_multi = freq_q > dkp_pkg::FREQ_RESET;
  assign upper_turn = freq_multi && (phase_inc >= {1'b0, freq_q});

  always_comb begin
    wr_addr  = best_idx_q;
    data_we  = 1'b0;
    valid_we = 1'b0;
    valid_wd = 1'b0;
    wr_entry.lower  = lower_q;
    wr_entry.upper  = upper_q;
    wr_entry.handle = handle_q;
    wr_entry.seq    = next_seq_q;
    unique case (state_q)
      S_CLEAR: begin
        wr_addr  = cnt_q[IW-1:0];
        valid_we = 1'b1;
      end
      S_SCAN: begin
        if (op_q == dkp_pkg::MODE_PRUNE && prune_hit) begin
          wr_addr  = ridx_q;
          valid_we = 1'b1;
        end
      end
      S_FIN: begin
        if (fin_go && found_q) begin
          if (op_q == dkp_pkg::MODE_INSERT) begin
            data_we  = 1'b1;
            valid_we = 1'b1;
            valid_wd = 1'b1;
          end else if (op_q == dkp_pkg::MODE_EXTRACT) begin
            valid_we = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      op_q        <= dkp_pkg::MODE_NOP;
      by_upper_q  <= 1'b0;
      found_q     <= 1'b0;
      rm_cnt_q    <= '0;
      next_seq_q  <= '0;
      total_q     <= '0;
      phase_q     <= '0;
      freq_q      <= dkp_pkg::FREQ_RESET;
      out_valid_q <= 1'b0;
    end else begin
      rv_q <= (state_q == S_SCAN) && (cnt_q < CAP_CNT);
      if (cfg_i.valid) begin
        freq_q <= cfg_i.data;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (cnt_q[IW-1:0] == LAST_IDX) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q       <= in_i.mode;
            by_upper_q <= upper_turn;
            found_q    <= 1'b0;
            rm_cnt_q   <= '0;
            cnt_q      <= '0;
            state_q    <= (in_i.mode == dkp_pkg::MODE_NOP) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_q < CAP_CNT) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if ((op_q == dkp_pkg::MODE_INSERT && free_hit) ||
              (op_q == dkp_pkg::MODE_EXTRACT && take)) begin
            found_q <= 1'b1;
          end
          if (op_q == dkp_pkg::MODE_PRUNE && prune_hit) begin
            rm_cnt_q <= rm_cnt_q + CW'(1);
          end
          if (rv_q && ridx_q == LAST_IDX) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state_q <= S_IDLE;
            if (op_q == dkp_pkg::MODE_INSERT && found_q) begin
              next_seq_q <= next_seq_q + 32'd1;
              total_q    <= total_q + 32'd1;
            end
            if (op_q == dkp_pkg::MODE_EXTRACT && found_q) begin
              phase_q <= (by_upper_q || !freq_multi) ? '0 : phase_inc[dkp_pkg::FREQ_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= cnt_q[IW-1:0];
    if (accept) begin
      lower_q  <= in_i.lower_bound;
      upper_q  <= in_i.upper_bound;
      handle_q <= in_i.node_handle;
      thr_q    <= in_i.threshold;
    end
    if (state_q == S_SCAN) begin
      if (op_q == dkp_pkg::MODE_INSERT && free_hit) begin
        best_idx_q <= ridx_q;
      end
      if (op_q == dkp_pkg::MODE_EXTRACT && take) begin
        best_idx_q    <= ridx_q;
        best_key_q    <= key;
        best_age_q    <= a_age;
        best_lower_q  <= rd_entry.lower;
        best_upper_q  <= rd_entry.upper;
        best_handle_q <= rd_entry.handle;
      end
    end
    if (fin_go) begin
      out_status_q  <= dkp_pkg::STATUS_DONE;
      out_handle_q  <= '0;
      out_lower_q   <= '0;
      out_upper_q   <= '0;
      out_removed_q <= '0;
      out_total_q   <= total_q;
      unique case (op_q)
        dkp_pkg::MODE_INSERT: begin
          if (found_q) begin
            out_total_q <= total_q + 32'd1;
          end else begin
            out_status_q <= dkp_pkg::STATUS_FULL;
          end
        end
        dkp_pkg::MODE_EXTRACT: begin
          if (found_q) begin
            out_handle_q <= best_handle_q;
            out_lower_q  <= best_lower_q;
            out_upper_q  <= best_upper_q;
          end else begin
            out_status_q <= dkp_pkg::STATUS_EMPTY;
          end
        end
        dkp_pkg::MODE_PRUNE: begin
          out_removed_q <= dkp_pkg::count_t'(rm_cnt_q);
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.out_handle     = out_handle_q;
  assign out_o.out_lower      = out_lower_q;
  assign out_o.out_upper      = out_upper_q;
  assign out_o.removed_count  = out_removed_q;
  assign out_o.inserted_total = out_total_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("Request channel stayed ready after accepting a word.");

  a_total_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(total_q) |-> ($past(state_q) == S_FIN && $past(op_q) == dkp_pkg::MODE_INSERT))
    else $error("Inserted total changed outside the end of an insert.");

  a_failed_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != dkp_pkg::STATUS_DONE) |->
    (out_o.out_handle == '0 && out_o.removed_count == '0))
    else $error("Failed result word carries node or prune data.");

endmodule
